### design/q2e_pkg.sv
package q2e_pkg;

	// Width of product sums in Q.30 (1.0 = 2^30); magnitudes stay below 2^33
	localparam int PW = 36;
	// Width of the CORDIC x/y datapath; gain 1.65 on a 2^33 vector stays below 2^35
	localparam int CW = 37;
	// Width of the square root radicand and partial root
	localparam int RW = 62;
	// One root bit per cell: the root of a value up to 2^60 has 31 bits
	localparam int SQ_CELLS = 31;

	localparam logic signed [PW-1:0] ONE_Q30 = PW'(64'sd1 << 30);

	// atan(2^-i) in 32-bit binary angle units (2^32 = 2 pi)
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic                 zero;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]          acc;
	} cord_t;

	typedef struct packed {
		logic                 sat;
		logic signed [PW-1:0] ry;
		logic signed [PW-1:0] rx;
		logic signed [PW-1:0] py;
		logic signed [PW-1:0] yy;
		logic signed [PW-1:0] yx;
	} side_t;

	// Zero test and pre-rotation by pi for a vector in the left half plane
	function automatic cord_t cord_entry(logic signed [PW-1:0] y, logic signed [PW-1:0] x);
		cord_t c;
		c.zero = (x == '0) && (y == '0);
		c.x    = CW'(x);
		c.y    = CW'(y);
		c.acc  = '0;
		if (x < 0) begin
			c.x   = -CW'(x);
			c.y   = -CW'(y);
			c.acc = 32'h80000000;
		end
		return c;
	endfunction

	// Round a 32-bit binary angle to 16 bits; a zero vector gives angle 0
	function automatic logic [15:0] angle_out(cord_t c);
		logic [31:0] r;
		r = c.acc + 32'h00008000;
		return c.zero ? 16'h0000 : r[31:16];
	endfunction

endpackage

### design/q2e_sqrt_cell.sv
module q2e_sqrt_cell
	import q2e_pkg::*;
#(
	parameter int J = 0
) (
	input  logic          clk,
	input  logic [RW-1:0] n_in,
	input  logic [RW-1:0] r_in,
	output logic [RW-1:0] n_out,
	output logic [RW-1:0] r_out
);

	localparam logic [RW-1:0] BIT = RW'(1) << (60 - 2*J);

	logic [RW-1:0] trial;

	assign trial = r_in + BIT;

	// settle one root bit: subtract the trial value when it fits
	always_ff @(posedge clk) begin
		if (n_in >= trial) begin
			n_out <= n_in - trial;
			r_out <= (r_in >> 1) + BIT;
		end else begin
			n_out <= n_in;
			r_out <= r_in >> 1;
		end
	end

endmodule

### design/q2e_cordic_cell.sv
module q2e_cordic_cell
	import q2e_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  cord_t c_in,
	output cord_t c_out
);

	logic signed [CW-1:0] xs, ys;

	assign xs = c_in.x >>> IDX;
	assign ys = c_in.y >>> IDX;

	// rotate toward the x axis and accumulate the step angle
	always_ff @(posedge clk) begin
		c_out.zero <= c_in.zero;
		if (c_in.y > 0) begin
			c_out.x   <= c_in.x + ys;
			c_out.y   <= c_in.y - xs;
			c_out.acc <= c_in.acc + ATAN_TAB[IDX];
		end else begin
			c_out.x   <= c_in.x - ys;
			c_out.y   <= c_in.y + xs;
			c_out.acc <= c_in.acc - ATAN_TAB[IDX];
		end
	end

endmodule

### design/quaternion_to_euler.sv
// Pipeline: a result strobes on done after 3 product/sum stages, 31 square root cells,
//   one CORDIC cell per step (steps above 32 count as 32)
//   and the output register.
// Throughput: one transaction per cycle; busy is always low, every stage advances each cycle.
// Reset: arst_n clears the valid chain at once; the datapath carries no reset.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module quaternion_to_euler
	import q2e_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [SAMPLE_WIDTH-1:0] q_w,
	input  logic signed [SAMPLE_WIDTH-1:0] q_x,
	input  logic signed [SAMPLE_WIDTH-1:0] q_y,
	input  logic signed [SAMPLE_WIDTH-1:0] q_z,
	output logic                           done,
	output logic signed [15:0]             roll_angle,
	output logic signed [15:0]             pitch_angle,
	output logic signed [15:0]             yaw_angle,
	output logic                           clamped
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int LAT   = 3 + SQ_CELLS + STEPS + 1;
	localparam int NPROD = 9;

	// product order: wa bc aa bb wb ca wc ab cc
	logic signed [2*SW-1:0] prod    [NPROD];
	logic signed [PW-1:0]   prod_q30[NPROD];
	logic signed [PW-1:0]   prod_s1 [NPROD];
	logic                   vld_s1;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign prod[0] = q_w * q_x;
	assign prod[1] = q_y * q_z;
	assign prod[2] = q_x * q_x;
	assign prod[3] = q_y * q_y;
	assign prod[4] = q_w * q_y;
	assign prod[5] = q_z * q_x;
	assign prod[6] = q_w * q_z;
	assign prod[7] = q_x * q_y;
	assign prod[8] = q_z * q_z;

	// scale each raw product to Q.30 with floor rounding
	for (genvar k = 0; k < NPROD; k++) begin : g_scale
		if (2*SW <= 32) begin : g_up
			assign prod_q30[k] = PW'(prod[k]) <<< (32 - 2*SW);
		end else begin : g_down
			assign prod_q30[k] = PW'(prod[k] >>> (2*SW - 32));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NPROD; k++) begin
			prod_s1[k] <= prod_q30[k];
		end
	end

	// stage 2: form the atan2 arguments and clamp the arcsine argument
	logic signed [PW-1:0] s_raw;
	logic                 vld_s2;
	side_t                side_s2;
	side_t                side_q [SQ_CELLS+1];
	logic [SQ_CELLS:0]    sv_q;

	assign s_raw = (prod_s1[4] - prod_s1[5]) <<< 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2.ry <= (prod_s1[0] + prod_s1[1]) <<< 1;
		side_s2.rx <= ONE_Q30 - ((prod_s1[2] + prod_s1[3]) <<< 1);
		side_s2.yy <= (prod_s1[6] + prod_s1[7]) <<< 1;
		side_s2.yx <= ONE_Q30 - ((prod_s1[3] + prod_s1[8]) <<< 1);
		if (s_raw > ONE_Q30) begin
			side_s2.py  <= ONE_Q30;
			side_s2.sat <= 1'b1;
		end else if (s_raw < -ONE_Q30) begin
			side_s2.py  <= -ONE_Q30;
			side_s2.sat <= 1'b1;
		end else begin
			side_s2.py  <= s_raw;
			side_s2.sat <= 1'b0;
		end
	end

	// stage 3: square the clamped argument for the cosine term
	logic [30:0]   mag;
	logic [RW-1:0] sq_s3;
	logic [RW-1:0] sq_n [SQ_CELLS+1];
	logic [RW-1:0] sq_r [SQ_CELLS+1];

	assign mag = (side_s2.py < 0) ? 31'(-side_s2.py) : 31'(side_s2.py);

	always_ff @(posedge clk) begin
		sq_s3 <= RW'(mag) * RW'(mag);
	end

	// square root chain: one cell settles one root bit of 2^60 - s^2
	assign sq_n[0] = (RW'(1) << 60) - sq_s3;
	assign sq_r[0] = '0;

	for (genvar j = 0; j < SQ_CELLS; j++) begin : g_sqrt
		q2e_sqrt_cell #(.J(j)) u_cell (
			.clk   (clk),
			.n_in  (sq_n[j]),
			.r_in  (sq_r[j]),
			.n_out (sq_n[j+1]),
			.r_out (sq_r[j+1])
		);
	end

	// hold the other operands alongside the root cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q <= '0;
		end else begin
			sv_q[0] <= vld_s2;
			for (int j = 1; j <= SQ_CELLS; j++) begin
				sv_q[j] <= sv_q[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_s2;
		for (int j = 1; j <= SQ_CELLS; j++) begin
			side_q[j] <= side_q[j-1];
		end
	end

	// three CORDIC chains in lockstep: roll, pitch, yaw
	cord_t cr [STEPS+1];
	cord_t cp [STEPS+1];
	cord_t cy [STEPS+1];
	logic [STEPS:0] cv_q;
	logic [STEPS:0] cs_q;

	assign cr[0] = cord_entry(side_q[SQ_CELLS].ry, side_q[SQ_CELLS].rx);
	assign cp[0] = cord_entry(side_q[SQ_CELLS].py, PW'(sq_r[SQ_CELLS]));
	assign cy[0] = cord_entry(side_q[SQ_CELLS].yy, side_q[SQ_CELLS].yx);
	assign cv_q[0] = sv_q[SQ_CELLS];
	assign cs_q[0] = side_q[SQ_CELLS].sat;

	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		q2e_cordic_cell #(.IDX(i)) u_roll  (.clk(clk), .c_in(cr[i]), .c_out(cr[i+1]));
		q2e_cordic_cell #(.IDX(i)) u_pitch (.clk(clk), .c_in(cp[i]), .c_out(cp[i+1]));
		q2e_cordic_cell #(.IDX(i)) u_yaw   (.clk(clk), .c_in(cy[i]), .c_out(cy[i+1]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q[STEPS:1] <= '0;
		end else begin
			cv_q[STEPS:1] <= cv_q[STEPS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		cs_q[STEPS:1] <= cs_q[STEPS-1:0];
	end

	// output register: round the angles, strobe done for one cycle
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cv_q[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		roll_angle  <= angle_out(cr[STEPS]);
		pitch_angle <= angle_out(cp[STEPS]);
		yaw_angle   <= angle_out(cy[STEPS]);
		clamped     <= cs_q[STEPS];
	end

	assign done = done_q;

	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("accepted transaction produced no result");

	a_lat_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without an accepted transaction");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q[SQ_CELLS] |-> (sq_r[SQ_CELLS] <= (RW'(1) << 30)))
		else $error("square root out of range");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("pipeline reported busy");

endmodule

### dv/quaternion_to_euler_tb.sv
`timescale 1ns / 100ps

module quaternion_to_euler_tb;

	localparam int SW    = 16;
	localparam int STEPS = 16;
	localparam int DRAIN = 35 + STEPS + 10;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [SW-1:0] q_w;
	logic signed [SW-1:0] q_x;
	logic signed [SW-1:0] q_y;
	logic signed [SW-1:0] q_z;
	logic                 done;
	logic signed [15:0]   roll_angle;
	logic signed [15:0]   pitch_angle;
	logic signed [15:0]   yaw_angle;
	logic                 clamped;

	typedef struct packed {
		logic [15:0] roll;
		logic [15:0] pitch;
		logic [15:0] yaw;
		logic        sat;
	} euler_t;

	euler_t euler_q[$];
	bit     failed = 0;

	// atan(2^-i) in 32-bit binary angle units, 2^32 = 2 pi
	localparam logic [31:0] ARCTAN [16] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	quaternion_to_euler #(
		.SAMPLE_WIDTH(SW),
		.CORDIC_STEPS(STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.q_w(q_w),
		.q_x(q_x),
		.q_y(q_y),
		.q_z(q_z),
		.done(done),
		.roll_angle(roll_angle),
		.pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle),
		.clamped(clamped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Product of two Q1.31 values, floored to Q.30
	function automatic longint prod_q30(longint a, longint b);
		return (a * b) >>> 32;
	endfunction

	// Largest r with r*r <= n, built one bit at a time
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	// Vectoring CORDIC arctangent, rounded to a 16-bit binary angle
	function automatic logic [15:0] vector_angle(longint y, longint x);
		logic [31:0] acc;
		longint      xs;
		longint      ys;
		acc = '0;
		if (x == 0 && y == 0)
			return 16'h0000;
		if (x < 0) begin
			// rotate into the right half plane; +pi and -pi share one code
			acc = 32'h80000000;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				acc = acc + ARCTAN[i];
			end else begin
				x = x - ys;
				y = y + xs;
				acc = acc - ARCTAN[i];
			end
		end
		acc = acc + 32'h00008000;
		return acc[31:16];
	endfunction

	// ZYX Euler angles of an unnormalized quaternion, asin argument saturated
	function automatic euler_t zyx_angles(logic signed [SW-1:0] qw, logic signed [SW-1:0] qx,
			logic signed [SW-1:0] qy, logic signed [SW-1:0] qz);
		longint  one;
		longint  w;
		longint  a;
		longint  b;
		longint  c;
		longint  s;
		longint  mag;
		longint  root;
		euler_t  e;
		one = 64'sd1 <<< 30;
		w = longint'(qw) <<< (32 - SW);
		a = longint'(qx) <<< (32 - SW);
		b = longint'(qy) <<< (32 - SW);
		c = longint'(qz) <<< (32 - SW);
		e.sat = 1'b0;
		s = 2 * (prod_q30(w, b) - prod_q30(c, a));
		if (s > one) begin
			s = one;
			e.sat = 1'b1;
		end else if (s < -one) begin
			s = -one;
			e.sat = 1'b1;
		end
		mag = (s < 0) ? -s : s;
		root = longint'(root_floor((64'd1 << 60) - longint'(mag * mag)));
		e.roll  = vector_angle(2 * (prod_q30(w, a) + prod_q30(b, c)),
			one - 2 * (prod_q30(a, a) + prod_q30(b, b)));
		e.pitch = vector_angle(s, root);
		e.yaw   = vector_angle(2 * (prod_q30(w, c) + prod_q30(a, b)),
			one - 2 * (prod_q30(b, b) + prod_q30(c, c)));
		return e;
	endfunction

	// Predict on every accepted transaction; inputs are sampled before the edge updates them
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			euler_q.push_back(zyx_angles(q_w, q_x, q_y, q_z));
	end

	// Compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		euler_t exp_e;
		if (arst_n && done) begin
			if (euler_q.size() == 0) begin
				$display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d clamped=%0b",
					$time, roll_angle, pitch_angle, yaw_angle, clamped);
				failed = 1;
			end else begin
				exp_e = euler_q.pop_front();
				if (roll_angle !== exp_e.roll) begin
					$display("%0t: roll expected %0d actual %0d", $time,
						$signed(exp_e.roll), roll_angle);
					failed = 1;
				end
				if (pitch_angle !== exp_e.pitch) begin
					$display("%0t: pitch expected %0d actual %0d", $time,
						$signed(exp_e.pitch), pitch_angle);
					failed = 1;
				end
				if (yaw_angle !== exp_e.yaw) begin
					$display("%0t: yaw expected %0d actual %0d", $time,
						$signed(exp_e.yaw), yaw_angle);
					failed = 1;
				end
				if (clamped !== exp_e.sat) begin
					$display("%0t: clamped expected %0b actual %0b", $time,
						exp_e.sat, clamped);
					failed = 1;
				end
			end
		end
	end

	// Mostly back to back, sometimes short pauses, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Hold one quaternion on the ports until the block takes it, then drop start for the gap if it is nonzero
	task automatic send_quat(logic signed [SW-1:0] w, logic signed [SW-1:0] x,
			logic signed [SW-1:0] y, logic signed [SW-1:0] z, int gap);
		start <= 1'b1;
		q_w   <= w;
		q_x   <= x;
		q_y   <= y;
		q_z   <= z;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
		end
		@(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_directed();
		// identity, zero and full-scale components
		send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0, 0);
		send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
		send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 1);
		send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0, 0);
		send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd0, 0);
		send_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0, 2);
		send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768, 0);
		send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0);
		send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0);
		// asin argument saturated high and low
		send_quat(16'sd32767, 16'sd0, 16'sd32767, 16'sd0, 0);
		send_quat(16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 3);
		send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd32767, 0);
		// gimbal lock near +-90 degrees pitch
		send_quat(16'sd23170, 16'sd0, 16'sd23170, 16'sd0, 0);
		send_quat(16'sd23170, 16'sd0, -16'sd23170, 16'sd0, 0);
		// left half plane with zero y: angle of pi
		send_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 0);
		send_quat(16'sd0, 16'sd23170, 16'sd23170, 16'sd0, 0);
		// left half plane with small positive and negative y
		send_quat(16'sd100, 16'sd32000, 16'sd0, 16'sd0, 0);
		send_quat(-16'sd100, 16'sd32000, 16'sd0, 16'sd0, 0);
		// tiny non-unit quaternions and a unit quaternion with equal components
		send_quat(16'sd1, 16'sd1, -16'sd1, 16'sd1, 0);
		send_quat(-16'sd1, 16'sd0, 16'sd0, 16'sd1, 5);
		send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0);
	endtask

	task automatic test_random(int count);
		logic signed [SW-1:0] c[4];
		int                   kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			for (int k = 0; k < 4; k++) begin
				if (kind < 6)
					c[k] = SW'($urandom);
				else if (kind < 8)
					c[k] = SW'($signed($urandom_range(0, 33000)) - 16500);
				else
					c[k] = SW'($signed($urandom_range(0, 16)) - 8);
			end
			// sometimes pin one component to a full-scale value
			if ($urandom_range(0, 19) == 0)
				c[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
			send_quat(c[0], c[1], c[2], c[3], pick_gap());
		end
	endtask

	initial begin
		int waited;
		clk    = 1'b0;
		arst_n = 1'b0;
		start  = 1'b0;
		q_w    = '0;
		q_x    = '0;
		q_y    = '0;
		q_z    = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(900);

		start <= 1'b0;
		waited = 0;
		while (euler_q.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		if (euler_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, euler_q.size());
			failed = 1;
		end
		repeat (DRAIN) @(posedge clk);

		if (!failed)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Drop the run if it hangs
	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### sim.f
design/q2e_pkg.sv
design/q2e_sqrt_cell.sv
design/q2e_cordic_cell.sv
design/quaternion_to_euler.sv
dv/quaternion_to_euler_tb.sv
